// ===== design/hkpm_pkg.sv =====
package hkpm_pkg;

    // Field widths
    localparam int CHAN_W   = 8;
    localparam int HUE_W    = 9;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 40;
    localparam int CFG_IDX_W = 1;

    // Divider widths: 60 * num fits in 14 bits, quotient never exceeds 60
    localparam int PROD_W   = 14;
    localparam int QUO_W    = 6;

    // Sector bases and wrap point in degrees
    localparam logic [HUE_W-1:0] BASE_RED   = 9'd0;
    localparam logic [HUE_W-1:0] BASE_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] BASE_BLUE  = 9'd240;
    localparam logic [HUE_W-1:0] BASE_WRAP  = 9'd360;
    localparam logic [HUE_W:0]   HUE_FULL   = 10'd360;

    // Window after reset
    localparam logic [HUE_W-1:0] HUE_LOW_RST  = 9'd40;
    localparam logic [HUE_W-1:0] HUE_HIGH_RST = 9'd80;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 1'b1;

    // Word carried between pipeline stages
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [HUE_W-1:0]  base;
        logic              sub;
        logic [CHAN_W-1:0] den;
        logic [PROD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } hkpm_stage_t;

    // Two restoring divide steps for quotient bits pos and pos-1
    function automatic logic [PROD_W+1:0] div_pair(
        input logic [PROD_W-1:0] rem,
        input logic [CHAN_W-1:0] den,
        input logic [2:0]        pos
    );
        logic [PROD_W:0]   trial;
        logic [PROD_W-1:0] dsh;
        logic [PROD_W-1:0] r;
        logic [1:0]        q;
        r = rem;
        q = 2'b00;
        dsh = {6'b0, den} << pos;
        trial = {1'b0, r} - {1'b0, dsh};
        if (!trial[PROD_W]) begin
            r    = trial[PROD_W-1:0];
            q[1] = 1'b1;
        end
        dsh = {6'b0, den} << (pos - 3'd1);
        trial = {1'b0, r} - {1'b0, dsh};
        if (!trial[PROD_W]) begin
            r    = trial[PROD_W-1:0];
            q[0] = 1'b1;
        end
        return {r, q};
    endfunction

endpackage

// ===== design/hue_key_pixel_mask_unit.sv =====
// Hue color key. Throughput one word per cycle when m_tready does not stall the
// output; the six-stage pipeline (sector decode, multiply by 60, three 2-bit
// divide stages, hue/window compare) fills bubbles.
// Reset (aresetn low, synchronous) empties every stage and loads the
// window 40..80.
module hue_key_pixel_mask_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Config write port
    input  logic                            cfg_wr_en,
    input  logic [hkpm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [hkpm_pkg::HUE_W-1:0]      cfg_wdata,
    // Input pixel: red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hkpm_pkg::IN_W-1:0]       s_tdata,
    // Output: red_out [7:0], green_out [15:8], blue_out [23:16],
    // hue_deg [32:24], zeros [39:33]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hkpm_pkg::OUT_W-1:0]      m_tdata,
    // Output flag: kept [0]
    output logic                            m_tuser
);
    import hkpm_pkg::*;

    localparam int NSTG = 5;

    logic [HUE_W-1:0]  hue_low_reg;
    logic [HUE_W-1:0]  hue_high_reg;
    logic              valid_reg [NSTG];
    hkpm_stage_t       stage_reg [NSTG];
    hkpm_stage_t       stage_next [NSTG];
    logic              en [NSTG];
    logic              out_en;
    logic              out_valid_reg;
    logic [CHAN_W-1:0] red_out_reg;
    logic [CHAN_W-1:0] green_out_reg;
    logic [CHAN_W-1:0] blue_out_reg;
    logic [HUE_W-1:0]  hue_out_reg;
    logic              kept_reg;
    logic [CHAN_W-1:0] r_in;
    logic [CHAN_W-1:0] g_in;
    logic [CHAN_W-1:0] b_in;
    logic [CHAN_W-1:0] num_in;
    logic [HUE_W:0]    hue_sum;
    logic [HUE_W-1:0]  hue_next;
    logic              keep_next;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_low_reg  <= HUE_LOW_RST;
            hue_high_reg <= HUE_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HUE_LOW:  hue_low_reg  <= cfg_wdata;
                REG_HUE_HIGH: hue_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage advances when empty or when the next one advances
    assign out_en = !out_valid_reg || m_tready;
    always_comb begin
        en[NSTG-1] = !valid_reg[NSTG-1] || out_en;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end
    assign s_tready = en[0];

    // Stage 0: pick the sector, numerator and denominator
    assign r_in = s_tdata[7:0];
    assign g_in = s_tdata[15:8];
    assign b_in = s_tdata[23:16];

    always_comb begin
        stage_next[0]       = '0;
        stage_next[0].red   = r_in;
        stage_next[0].green = g_in;
        stage_next[0].blue  = b_in;
        stage_next[0].base  = BASE_RED;
        stage_next[0].sub   = 1'b0;
        stage_next[0].den   = 8'd1;
        num_in              = '0;
        if (r_in > g_in && g_in >= b_in) begin
            stage_next[0].base = BASE_RED;
            num_in             = g_in - b_in;
            stage_next[0].den  = r_in - b_in;
        end else if (g_in >= r_in && r_in > b_in) begin
            stage_next[0].base = BASE_GREEN;
            stage_next[0].sub  = 1'b1;
            num_in             = r_in - b_in;
            stage_next[0].den  = g_in - b_in;
        end else if (g_in > b_in && b_in >= r_in) begin
            stage_next[0].base = BASE_GREEN;
            num_in             = b_in - r_in;
            stage_next[0].den  = g_in - r_in;
        end else if (b_in >= g_in && g_in > r_in) begin
            stage_next[0].base = BASE_BLUE;
            stage_next[0].sub  = 1'b1;
            num_in             = g_in - r_in;
            stage_next[0].den  = b_in - r_in;
        end else if (b_in > r_in && r_in >= g_in) begin
            stage_next[0].base = BASE_BLUE;
            num_in             = r_in - g_in;
            stage_next[0].den  = b_in - g_in;
        end else if (r_in >= b_in && b_in > g_in) begin
            stage_next[0].base = BASE_WRAP;
            stage_next[0].sub  = 1'b1;
            num_in             = b_in - g_in;
            stage_next[0].den  = r_in - g_in;
        end
        // grey falls through with zero numerator: quotient and hue are zero
        stage_next[0].rem = {6'b0, num_in};
    end

    // Stage 1: multiply numerator by 60 as 64x - 4x
    always_comb begin
        stage_next[1]     = stage_reg[0];
        stage_next[1].rem = (stage_reg[0].rem << 6) - (stage_reg[0].rem << 2);
    end

    // Stages 2..4: two quotient bits each, most significant first
    for (genvar j = 0; j < 3; j++) begin : g_div
        logic [PROD_W+1:0] step;
        assign step = div_pair(stage_reg[j+1].rem, stage_reg[j+1].den, 3'(5 - 2 * j));
        always_comb begin
            stage_next[j+2]     = stage_reg[j+1];
            stage_next[j+2].rem = step[PROD_W+1:2];
            stage_next[j+2].quo = {stage_reg[j+1].quo[QUO_W-3:0], step[1:0]};
        end
    end

    // Pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSTG; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0] && s_tvalid) begin
            stage_reg[0] <= stage_next[0];
        end
        for (int i = 1; i < NSTG; i++) begin
            if (en[i] && valid_reg[i-1]) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // Final stage: apply sector base, wrap 360, test the window
    always_comb begin
        if (stage_reg[NSTG-1].sub) begin
            hue_sum = {1'b0, stage_reg[NSTG-1].base} - {4'b0, stage_reg[NSTG-1].quo};
        end else begin
            hue_sum = {1'b0, stage_reg[NSTG-1].base} + {4'b0, stage_reg[NSTG-1].quo};
        end
        if (hue_sum >= HUE_FULL) begin
            hue_sum = hue_sum - HUE_FULL;
        end
        hue_next  = hue_sum[HUE_W-1:0];
        keep_next = (hue_next >= hue_low_reg) && (hue_next <= hue_high_reg);
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= valid_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && valid_reg[NSTG-1]) begin
            red_out_reg   <= keep_next ? stage_reg[NSTG-1].red   : '0;
            green_out_reg <= keep_next ? stage_reg[NSTG-1].green : '0;
            blue_out_reg  <= keep_next ? stage_reg[NSTG-1].blue  : '0;
            hue_out_reg   <= hue_next;
            kept_reg      <= keep_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, hue_out_reg, blue_out_reg, green_out_reg, red_out_reg};
    assign m_tuser  = kept_reg;

`ifndef SYNTH
    // A masked word carries black
    a_mask_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[23:0] == 24'd0))
        else $error("masked word is not black");

    // Hue stays below a full turn
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (hue_out_reg < HUE_FULL[HUE_W-1:0] || hue_out_reg == 9'd0))
        else $error("hue out of range");

    // A kept word lies inside the window
    a_kept_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (hue_out_reg >= hue_low_reg && hue_out_reg <= hue_high_reg))
        else $error("kept word outside window");

    // Input stalls only when the first stage holds a word
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> valid_reg[0])
        else $error("input stalled with empty first stage");
`endif

endmodule
